/* src/rc_pwm_four_channel_decoder_core_defines.svh */
// assertion macros for the rc pwm decoder core
// expects clk and rst_n in the scope where the macros are used
`ifndef RC_PWM_FOUR_CHANNEL_DECODER_CORE_DEFINES_SVH
`define RC_PWM_FOUR_CHANNEL_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define RCPWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/rcpwm_pkg.sv */
// shared types and constants of the rc pwm decoder core
// no dependencies
`default_nettype none

package rcpwm_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int TIMEOUT_MS_DEF = 50;

    localparam int PULSE_W      = 14;
    localparam int AGE_W        = 6;
    localparam int MAP_W        = 3;
    localparam int CHAN_W       = 2;
    localparam int CAL_W        = 56;
    localparam int TICK_W       = 24;
    localparam int SUM_W        = TICK_W + 1;
    localparam int AXIS_W       = 15;
    localparam int SLIDE_W      = 2;
    localparam int OUT_CHANNELS = 4;
    localparam int CAL_REGS     = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int FMAP_W       = 12;

    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 14;
    localparam int DIV_Q_W   = 14;
    localparam int DIV_STEPS = DIV_Q_W / 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_CAL0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLICKED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FMAP    = 3'd5;

    // function slots in the function map
    localparam logic [1:0] FN_STEER    = 2'd0;
    localparam logic [1:0] FN_THROTTLE = 2'd1;
    localparam logic [1:0] FN_AUX      = 2'd2;
    localparam logic [1:0] FN_SWITCH   = 2'd3;

    localparam logic [SLIDE_W-1:0] SLIDE_NONE = 2'd0;
    localparam logic [SLIDE_W-1:0] SLIDE_BACK = 2'd1;
    localparam logic [SLIDE_W-1:0] SLIDE_FWD  = 2'd2;
    localparam logic [SLIDE_W-1:0] SLIDE_MID  = 2'd3;

    localparam logic [FMAP_W-1:0] FMAP_RESET = 12'd1672;

    // period band 10000..28571 us expressed in ticks of high plus low
    localparam logic [SUM_W-1:0]     BAND_LO_TICKS = 25'd625000;
    localparam logic [SUM_W-1:0]     BAND_HI_TICKS = 25'd1785749;
    // from this high time on the pulse saturates
    localparam logic [TICK_W-1:0]    PW_SAT_TICKS  = 24'd1024000;
    localparam logic [PULSE_W-1:0]   PULSE_MAX     = 14'h3FFF;
    // 16 / 1000 reduces to 2 / 125
    localparam logic [DIV_DEN_W-1:0] PW_DEN        = 14'd125;
    localparam logic [PULSE_W-1:0]   SCALE_THR     = 14'd10000;
    localparam logic [PULSE_W-1:0]   SCALE_STR     = 14'd9000;
    localparam logic [AXIS_W-1:0]    STEER_MID     = 15'd9000;

    typedef logic signed [15:0] sval_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_PWDIV,
        S_AXA,
        S_AXB,
        S_AXC,
        S_AXW,
        S_SL,
        S_SW,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic               tick;
        logic               cap;
        logic [CHAN_W-1:0]  chan;
        logic [PULSE_W-1:0] pulse;
    } store_upd_t;

endpackage

`default_nettype wire

/* src/rcpwm_if.sv */
// handshake channels of the rc pwm decoder core: capture, result and config
// depends on rcpwm_pkg
`default_nettype none

interface rcpwm_cap_if import rcpwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAN_W-1:0] chan;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] space_ticks;

    modport source (output valid, func, chan, high_ticks, space_ticks, input ready);
    modport sink   (input valid, func, chan, high_ticks, space_ticks, output ready);
endinterface

interface rcpwm_res_if import rcpwm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [PULSE_W-1:0]       pulse_ch0;
    logic [PULSE_W-1:0]       pulse_ch1;
    logic [PULSE_W-1:0]       pulse_ch2;
    logic [PULSE_W-1:0]       pulse_ch3;
    logic signed [AXIS_W-1:0] throttle_hundredths;
    logic [AXIS_W-1:0]        steering_hundredths;
    logic [SLIDE_W-1:0]       slide_position;
    logic                     switch_on;

    modport source (output valid, pulse_ch0, pulse_ch1, pulse_ch2, pulse_ch3,
                    throttle_hundredths, steering_hundredths, slide_position,
                    switch_on, input ready);
    modport sink   (input valid, pulse_ch0, pulse_ch1, pulse_ch2, pulse_ch3,
                    throttle_hundredths, steering_hundredths, slide_position,
                    switch_on, output ready);
endinterface

interface rcpwm_cfg_if import rcpwm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/rcpwm_div.sv */
// shared iterative divider, two quotient bits per cycle
// depends on rcpwm_pkg; quotient must fit DIV_Q_W bits (num < den << DIV_Q_W)
`default_nettype none

module rcpwm_div import rcpwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quot
);

    localparam int LOW_W = DIV_NUM_W - DIV_DEN_W;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [LOW_W-1:0]     low_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   quot_reg;

    logic [DIV_DEN_W:0]   r1;
    logic [DIV_DEN_W:0]   r1s;
    logic [DIV_DEN_W:0]   r2;
    logic [DIV_DEN_W:0]   r2s;
    logic                 ge1;
    logic                 ge2;

    always_comb
    begin
        r1  = {rem_reg, low_reg[LOW_W-1]};
        ge1 = r1 >= {1'b0, den_reg};
        r1s = ge1 ? (r1 - {1'b0, den_reg}) : r1;
        r2  = {r1s[DIV_DEN_W-1:0], low_reg[LOW_W-2]};
        ge2 = r2 >= {1'b0, den_reg};
        r2s = ge2 ? (r2 - {1'b0, den_reg}) : r2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // top bits of the numerator start as the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DIV_NUM_W-1 -: DIV_DEN_W];
            low_reg <= num[LOW_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= r2s[DIV_DEN_W-1:0];
            low_reg  <= {low_reg[LOW_W-3:0], 2'b00};
            quot_reg <= {quot_reg[DIV_Q_W-3:0], ge1, ge2};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

/* src/rcpwm_store.sv */
// per-channel pulse store and millisecond age counters
// depends on rcpwm_pkg
`default_nettype none

module rcpwm_store import rcpwm_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int TIMEOUT_MS = TIMEOUT_MS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  store_upd_t                             upd,
    input  logic [MAP_W-1:0]                       rd_chan,
    output logic [PULSE_W-1:0]                     rd_pulse,
    output logic [OUT_CHANNELS-1:0][PULSE_W-1:0]   fix_pulse
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AGE_W-1:0] AGE_MAX    = AGE_W'(TIMEOUT_MS);
    localparam logic [MAP_W:0]   CHAN_LIMIT = (MAP_W + 1)'(CHANNELS);

    logic [PULSE_W-1:0] pulse_reg [CHANNELS];
    logic [AGE_W-1:0]   age_reg   [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pulse_reg[i] <= '0;
                age_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (upd.tick && (age_reg[i] < AGE_MAX))
                begin
                    age_reg[i] <= age_reg[i] + AGE_W'(1);
                end
                if (upd.cap && (int'(upd.chan) == i))
                begin
                    pulse_reg[i] <= upd.pulse;
                    age_reg[i]   <= '0;
                end
            end
        end
    end

    // selected read for the function being decoded, zero when stale
    always_comb
    begin
        rd_pulse = '0;
        if ({1'b0, rd_chan} < CHAN_LIMIT)
        begin
            if (age_reg[rd_chan[IDX_W-1:0]] < AGE_MAX)
            begin
                rd_pulse = pulse_reg[rd_chan[IDX_W-1:0]];
            end
        end
    end

    for (genvar g = 0; g < OUT_CHANNELS; g++)
    begin : g_fix
        if (g < CHANNELS)
        begin : g_live
            assign fix_pulse[g] = (age_reg[g] < AGE_MAX) ? pulse_reg[g] : '0;
        end
        else
        begin : g_none
            assign fix_pulse[g] = '0;
        end
    end

endmodule

`default_nettype wire

/* src/rc_pwm_four_channel_decoder_core.sv */
// four-channel rc pwm decoder: config registers, sequencer and axis datapath
// depends on rcpwm_pkg, rcpwm_if, rcpwm_div, rcpwm_store and the defines header
//
// usage
//   capture: one word per capture (func 0, chan, high and low ticks of 16 ns)
//            or per millisecond tick (func 1). every word gives one result word.
//   result:  the four channel pulses in us, throttle, steering, slide switch
//            and push switch, held in an output register until taken.
//   cfg:     register writes (calibration, clicked pulse, function map),
//            always ready; write only while no word is in flight.
//   divider: the shared divider computes the pulse width of a valid, unsaturated
//            capture and each of throttle and steering; axes at neutral skip it.
//   accept: capture ready is high only while the sequencer sits idle, so a new
//            word is taken only once the last one has reached the output register.
//   reset: pulses and ages clear, so all channels read zero; calibration
//            clears and the function map returns to steering 0, throttle 1,
//            aux 2, switch 3.
//   stall: a finished result waits in the output register; the next word is
//            taken meanwhile and its result waits until the register frees.
`default_nettype none

`include "rc_pwm_four_channel_decoder_core_defines.svh"

module rc_pwm_four_channel_decoder_core import rcpwm_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int TIMEOUT_MS = TIMEOUT_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    rcpwm_cap_if.sink   capture,
    rcpwm_res_if.source result,
    rcpwm_cfg_if.sink   cfg
);

    localparam logic [MAP_W:0] CHAN_LIMIT = (MAP_W + 1)'(CHANNELS);

    // configuration
    logic [CAL_W-1:0]   cal_reg [CAL_REGS];
    logic [PULSE_W-1:0] clicked_reg;
    logic [FMAP_W-1:0]  fmap_reg;

    // sequencer
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       fn_reg;

    // captured word
    logic              func_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [TICK_W-1:0] hi_reg;
    logic [TICK_W-1:0] lo_reg;

    // axis datapath
    sval_t              p_reg;
    sval_t              mn_reg;
    sval_t              mx_reg;
    sval_t              hiw_reg;
    sval_t              low_reg;
    logic               neutral_reg;
    logic [PULSE_W-1:0] n_reg;
    logic [PULSE_W-1:0] d_reg;
    logic               neg_reg;
    logic [AXIS_W-1:0]  thr_reg;
    logic [AXIS_W-1:0]  str_reg;
    logic [SLIDE_W-1:0] slide_reg;
    logic               sw_reg;

    // output register
    logic                                 out_full_reg;
    logic [OUT_CHANNELS-1:0][PULSE_W-1:0] out_pulse_reg;
    logic [AXIS_W-1:0]                    out_thr_reg;
    logic [AXIS_W-1:0]                    out_str_reg;
    logic [SLIDE_W-1:0]                   out_slide_reg;
    logic                                 out_sw_reg;

    logic [1:0]                           cur_fn;
    logic [MAP_W-1:0]                     map_chan;
    logic [CAL_W-1:0]                     cal_sel;
    logic [PULSE_W-1:0]                   sel_pulse;
    logic [OUT_CHANNELS-1:0][PULSE_W-1:0] fix_pulse;
    sval_t                                p_s;
    sval_t                                mn_s;
    sval_t                                md_s;
    sval_t                                mx_s;
    sval_t                                mg_s;
    sval_t                                clicked_s;
    logic                                 ax_neutral;
    logic                                 inwin;
    logic                                 up;
    sval_t                                pc;
    sval_t                                n_s;
    sval_t                                d_s;
    logic                                 ax_skip;
    logic                                 ax_commit;
    logic [AXIS_W-1:0]                    q15;
    logic                                 q_neg;
    logic [SUM_W-1:0]                     sum_ticks;
    logic                                 chan_valid;
    logic                                 cap_ok;
    logic                                 sat;
    logic                                 cap_direct;
    logic                                 cap_div;
    store_upd_t                           st_upd;
    logic                                 div_start;
    logic [DIV_NUM_W-1:0]                 div_num;
    logic [DIV_DEN_W-1:0]                 div_den;
    logic                                 div_busy;
    logic                                 div_done;
    logic [DIV_Q_W-1:0]                   div_quot;
    logic                                 div_wait;
    logic [PULSE_W-1:0]                   scale;
    logic                                 out_load;
    logic [SLIDE_W-1:0]                   slide_val;
    logic                                 sw_val;

    function automatic logic near(sval_t p, sval_t c, sval_t m);
        return (p >= c - m) && (p <= c + m);
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_REGS; i++)
            begin
                cal_reg[i] <= '0;
            end
            clicked_reg <= '0;
            fmap_reg    <= FMAP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CAL0, REG_CAL1, REG_CAL2, REG_CAL3:
                begin
                    cal_reg[cfg.index[1:0]] <= cfg.data;
                end
                REG_CLICKED:
                begin
                    clicked_reg <= cfg.data[PULSE_W-1:0];
                end
                REG_FMAP:
                begin
                    fmap_reg <= cfg.data[FMAP_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // channel selection for the function being decoded
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_AXA:   cur_fn = {1'b0, fn_reg};
            S_SL:    cur_fn = FN_AUX;
            S_SW:    cur_fn = FN_SWITCH;
            default: cur_fn = FN_STEER;
        endcase
    end

    assign map_chan = fmap_reg[cur_fn * MAP_W +: MAP_W];
    assign cal_sel  = (map_chan < MAP_W'(CAL_REGS)) ? cal_reg[map_chan[1:0]] : '0;

    assign p_s       = sval_t'({2'b00, sel_pulse});
    assign mn_s      = sval_t'({2'b00, cal_sel[0 * PULSE_W +: PULSE_W]});
    assign md_s      = sval_t'({2'b00, cal_sel[1 * PULSE_W +: PULSE_W]});
    assign mx_s      = sval_t'({2'b00, cal_sel[2 * PULSE_W +: PULSE_W]});
    assign mg_s      = sval_t'({2'b00, cal_sel[3 * PULSE_W +: PULSE_W]});
    assign clicked_s = sval_t'({2'b00, clicked_reg});

    // ------------------------------------------------------------------
    // capture update
    // ------------------------------------------------------------------
    assign sum_ticks  = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign chan_valid = {{(MAP_W + 1 - CHAN_W){1'b0}}, chan_reg} < CHAN_LIMIT;
    assign cap_ok     = !func_reg && chan_valid &&
                        (sum_ticks >= BAND_LO_TICKS) && (sum_ticks <= BAND_HI_TICKS);
    assign sat        = hi_reg >= PW_SAT_TICKS;
    assign cap_direct = (state_reg == S_UPD) && cap_ok && sat;
    assign cap_div    = (state_reg == S_PWDIV) && div_done;

    assign st_upd.tick  = (state_reg == S_UPD) && func_reg;
    assign st_upd.cap   = cap_direct || cap_div;
    assign st_upd.chan  = chan_reg;
    assign st_upd.pulse = cap_direct ? PULSE_MAX : div_quot;

    rcpwm_store #(
        .CHANNELS   (CHANNELS),
        .TIMEOUT_MS (TIMEOUT_MS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (st_upd),
        .rd_chan   (map_chan),
        .rd_pulse  (sel_pulse),
        .fix_pulse (fix_pulse)
    );

    // ------------------------------------------------------------------
    // axis datapath
    // ------------------------------------------------------------------
    assign ax_neutral = (sel_pulse == '0) ||
                        !((mn_s + mg_s < md_s) && (md_s + mg_s < mx_s));

    always_comb
    begin
        inwin = (p_reg >= low_reg) && (p_reg <= hiw_reg);
        up    = p_reg > hiw_reg;
        if (p_reg < mn_reg)
        begin
            pc = mn_reg;
        end
        else if (p_reg > mx_reg)
        begin
            pc = mx_reg;
        end
        else
        begin
            pc = p_reg;
        end
        n_s = up ? (pc - hiw_reg) : (low_reg - pc);
        d_s = up ? (mx_reg - hiw_reg) : (low_reg - mn_reg);
    end

    assign ax_skip   = neutral_reg || inwin;
    assign ax_commit = ((state_reg == S_AXB) && ax_skip) ||
                       ((state_reg == S_AXW) && div_done);
    assign q15       = (state_reg == S_AXW) ? {1'b0, div_quot} : '0;
    assign q_neg     = (state_reg == S_AXW) && neg_reg;
    assign scale     = fn_reg ? SCALE_THR : SCALE_STR;

    assign div_start = (state_reg == S_UPD && cap_ok && !sat) || (state_reg == S_AXC);
    assign div_num   = (state_reg == S_UPD) ?
                       {{(DIV_NUM_W - TICK_W - 1){1'b0}}, hi_reg, 1'b0} :
                       ({{PULSE_W{1'b0}}, n_reg} * {{PULSE_W{1'b0}}, scale});
    assign div_den   = (state_reg == S_UPD) ? PW_DEN : d_reg;
    assign div_wait  = (state_reg == S_PWDIV) || (state_reg == S_AXW);

    rcpwm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // slide and push switch
    always_comb
    begin
        if (sel_pulse == '0)
        begin
            slide_val = SLIDE_NONE;
        end
        else if (near(p_s, mn_s, mg_s))
        begin
            slide_val = SLIDE_BACK;
        end
        else if (near(p_s, mx_s, mg_s))
        begin
            slide_val = SLIDE_FWD;
        end
        else
        begin
            slide_val = SLIDE_MID;
        end
        sw_val = (sel_pulse != '0) && near(p_s, clicked_s, mg_s);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (capture.valid)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = (cap_ok && !sat) ? S_PWDIV : S_AXA;
            end
            S_PWDIV:
            begin
                if (div_done)
                begin
                    state_next = S_AXA;
                end
            end
            S_AXA:
            begin
                state_next = S_AXB;
            end
            S_AXB:
            begin
                if (ax_skip)
                begin
                    state_next = fn_reg ? S_SL : S_AXA;
                end
                else
                begin
                    state_next = S_AXC;
                end
            end
            S_AXC:
            begin
                state_next = S_AXW;
            end
            S_AXW:
            begin
                if (div_done)
                begin
                    state_next = fn_reg ? S_SL : S_AXA;
                end
            end
            S_SL:
            begin
                state_next = S_SW;
            end
            S_SW:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign capture.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_reg <= 1'b0;
        end
        else if (state_reg == S_UPD)
        begin
            fn_reg <= 1'b0;
        end
        else if (ax_commit)
        begin
            fn_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture.valid && capture.ready)
        begin
            func_reg <= capture.func;
            chan_reg <= capture.chan;
            hi_reg   <= capture.high_ticks;
            lo_reg   <= capture.space_ticks;
        end
        if (state_reg == S_AXA)
        begin
            p_reg       <= p_s;
            mn_reg      <= mn_s;
            mx_reg      <= mx_s;
            hiw_reg     <= md_s + mg_s;
            low_reg     <= md_s - mg_s;
            neutral_reg <= ax_neutral;
        end
        if (state_reg == S_AXB)
        begin
            n_reg   <= n_s[PULSE_W-1:0];
            d_reg   <= d_s[PULSE_W-1:0];
            neg_reg <= !up;
        end
        if (ax_commit)
        begin
            if (fn_reg)
            begin
                thr_reg <= q_neg ? (AXIS_W'(0) - q15) : q15;
            end
            else
            begin
                str_reg <= q_neg ? (STEER_MID - q15) : (STEER_MID + q15);
            end
        end
        if (state_reg == S_SL)
        begin
            slide_reg <= slide_val;
        end
        if (state_reg == S_SW)
        begin
            sw_reg <= sw_val;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_OUT) && (!out_full_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_full_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pulse_reg <= fix_pulse;
            out_thr_reg   <= thr_reg;
            out_str_reg   <= str_reg;
            out_slide_reg <= slide_reg;
            out_sw_reg    <= sw_reg;
        end
    end

    assign result.valid               = out_full_reg;
    assign result.pulse_ch0           = out_pulse_reg[0];
    assign result.pulse_ch1           = out_pulse_reg[1];
    assign result.pulse_ch2           = out_pulse_reg[2];
    assign result.pulse_ch3           = out_pulse_reg[3];
    assign result.throttle_hundredths = out_thr_reg;
    assign result.steering_hundredths = out_str_reg;
    assign result.slide_position      = out_slide_reg;
    assign result.switch_on           = out_sw_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RCPWM_ASSERT_SAME(a_div_start_free, div_start, !div_busy, "divider restarted while busy")
    `RCPWM_ASSERT_SAME(a_div_done_used, div_done, div_wait, "divider result not consumed")
    `RCPWM_ASSERT_NEXT(a_out_load_shown, out_load, result.valid, "loaded result not presented")

endmodule

`default_nettype wire
